// ----- rtl/rzd_pkg.sv -----
// rzd_pkg: shared constants and tables of the run-length zigzag dequantizer
// holds the zigzag order, the quantization table and the datapath widths
// no dependencies
package rzd_pkg;

    localparam int RUN_W   = 6;
    localparam int VAL_W   = 12;
    localparam int SCALE_W = 9;
    localparam int QT_W    = 7;
    localparam int COEF_W  = 28;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 3;

    // shared multiplier operand widths
    localparam int MUL_A_W = 19;
    localparam int MUL_B_W = 9;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 9'd256;
    localparam logic [POS_W-1:0]   POS_LAST    = 6'd63;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // zigzag position -> row*8 + col
    localparam logic [5:0] ZZ_ORDER [64] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    // quantization table in row-major order
    localparam logic [QT_W-1:0] QTABLE [64] = '{
        16, 11, 10, 16, 24, 40, 51, 61,
        12, 12, 14, 19, 26, 58, 60, 55,
        14, 13, 16, 24, 40, 57, 69, 56,
        14, 17, 22, 29, 51, 87, 80, 62,
        18, 22, 37, 56, 68, 109, 103, 77,
        24, 35, 55, 64, 81, 104, 113, 92,
        49, 64, 78, 87, 103, 121, 120, 101,
        72, 92, 95, 98, 112, 100, 103, 99
    };

endpackage

// ----- rtl/rle_zigzag_dequantizer_top.sv -----
// rle_zigzag_dequantizer_top: top level, sequencer and output register
// depends on rzd_pkg and rzd_mul
//
// Takes (zero_run, coef_value) pairs of an 8x8 block and emits coefficients
// in zigzag order, each with row, column, a last-of-block mark on tlast and
// the run overflow flag on tuser. The input is not ready while an item is
// being worked on. A data pair is accepted in ST_IDLE, emits its zeros in
// ST_ZERO, is paced by the shared multiplier in ST_MUL1 and ST_MUL2 and is
// emitted in ST_VAL. An end-of-block pair or an overflowing run emits zeros
// up to the block end; the pair after an overflow or a value at the last
// position is dropped. quality_scale is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which the
// block itself does not enforce. It resets to 1.0 (256).
module rle_zigzag_dequantizer_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [rzd_pkg::SCALE_W-1:0]      cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [5:0] zero_run, [17:6] coef_value
    input  logic [rzd_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [27:0] coefficient, [30:28] row_index, [33:31] col_index
    output logic [rzd_pkg::M_TDATA_W-1:0]    m_tdata,
    // block_last
    output logic                             m_tlast,
    // run_overflow
    output logic                             m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ZERO = 5'b00010,
        ST_MUL1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_VAL  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [rzd_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [rzd_pkg::RUN_W-1:0]       run_reg, run_next;
    logic signed [rzd_pkg::VAL_W-1:0] val_reg, val_next;
    logic                            await_reg, await_next;
    logic                            fill_reg, fill_next;
    logic                            ovf_reg, ovf_next;
    logic [rzd_pkg::SCALE_W-1:0]     scale_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [rzd_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic                            m_last_reg, m_last_next;
    logic                            m_user_reg, m_user_next;

    logic [rzd_pkg::RUN_W-1:0]       in_run;
    logic signed [rzd_pkg::VAL_W-1:0] in_val;
    logic                            in_accept;
    logic [rzd_pkg::POS_W:0]         end_sum;
    logic                            out_free;
    logic [5:0]                      zz_idx;

    logic                            mul_en;
    logic signed [rzd_pkg::MUL_A_W-1:0] mul_a;
    logic        [rzd_pkg::MUL_B_W-1:0] mul_b;
    logic signed [rzd_pkg::MUL_P_W-1:0] mul_p;

    assign in_run    = s_tdata[rzd_pkg::RUN_W-1:0];
    assign in_val    = $signed(s_tdata[rzd_pkg::RUN_W +: rzd_pkg::VAL_W]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign end_sum   = {1'b0, pos_reg} + {1'b0, in_run};
    assign out_free  = !m_valid_reg || m_tready;
    assign zz_idx    = rzd_pkg::ZZ_ORDER[pos_reg];

    assign mul_en = (state_reg == ST_MUL1) || (state_reg == ST_MUL2);
    assign mul_a  = (state_reg == ST_MUL1)
                    ? rzd_pkg::MUL_A_W'(val_reg)
                    : mul_p[rzd_pkg::MUL_A_W-1:0];
    assign mul_b  = (state_reg == ST_MUL1)
                    ? rzd_pkg::MUL_B_W'(rzd_pkg::QTABLE[zz_idx])
                    : scale_reg;

    rzd_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        run_next     = run_reg;
        val_next     = val_reg;
        await_next   = await_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    run_next = in_run;
                    val_next = in_val;
                    if (await_reg) begin
                        await_next = 1'b0;
                        pos_next   = '0;
                    end else if (in_run == '0 && in_val == '0) begin
                        fill_next  = 1'b1;
                        ovf_next   = 1'b0;
                        state_next = ST_ZERO;
                    end else if (end_sum > {1'b0, rzd_pkg::POS_LAST}) begin
                        fill_next  = 1'b1;
                        ovf_next   = 1'b1;
                        state_next = ST_ZERO;
                    end else begin
                        fill_next  = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = (in_run == '0) ? ST_MUL1 : ST_ZERO;
                    end
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, zz_idx[2:0], zz_idx[5:3],
                                    {rzd_pkg::COEF_W{1'b0}}};
                    m_last_next  = (pos_reg == rzd_pkg::POS_LAST);
                    m_user_next  = ovf_reg;
                    if (fill_reg) begin
                        if (pos_reg == rzd_pkg::POS_LAST) begin
                            pos_next   = '0;
                            await_next = ovf_reg;
                            state_next = ST_IDLE;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1;
                        run_next = run_reg - 1'b1;
                        if (run_reg == rzd_pkg::RUN_W'(1)) begin
                            state_next = ST_MUL1;
                        end
                    end
                end
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                state_next = ST_VAL;
            end
            ST_VAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, zz_idx[2:0], zz_idx[5:3],
                                    mul_p[rzd_pkg::COEF_W-1:0]};
                    m_last_next  = (pos_reg == rzd_pkg::POS_LAST);
                    m_user_next  = 1'b0;
                    state_next   = ST_IDLE;
                    if (pos_reg == rzd_pkg::POS_LAST) begin
                        pos_next   = '0;
                        await_next = 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            await_reg   <= 1'b0;
            fill_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
            scale_reg   <= rzd_pkg::SCALE_RESET;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            await_reg   <= await_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                scale_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // overflowing runs only ever carry zero coefficients
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[rzd_pkg::COEF_W-1:0] == '0)
        else $error("overflow item with nonzero coefficient");

    // a filled block always restarts at position zero
    a_await_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> pos_reg == '0)
        else $error("terminator pending with nonzero position");

    // second multiply pass follows the first
    a_mul_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL2 |-> $past(state_reg) == ST_MUL1)
        else $error("multiplier sequence broken");

    // a zero run of a data pair stays inside the block
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ZERO && !fill_reg
            |-> ({1'b0, pos_reg} + {1'b0, run_reg}) <= {1'b0, rzd_pkg::POS_LAST})
        else $error("zero run passes block end");

endmodule

// ----- rtl/rzd_mul.sv -----
// rzd_mul: shared signed-by-unsigned multiplier with registered product
// used twice per value item: value times table entry, then times scale
// depends on rzd_pkg
module rzd_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [rzd_pkg::MUL_A_W-1:0]   a,
    input  logic        [rzd_pkg::MUL_B_W-1:0]   b,
    output logic signed [rzd_pkg::MUL_P_W-1:0]   p
);

    logic signed [rzd_pkg::MUL_P_W-1:0] p_reg;
    logic signed [rzd_pkg::MUL_P_W-1:0] p_next;

    always_comb begin
        p_next = a * $signed({1'b0, b});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ----- tb/tb_rle_zigzag_dequantizer_top.sv -----
// tb_rle_zigzag_dequantizer_top: self-checking testbench of the run-length zigzag dequantizer
// drives (zero_run, coef_value) pairs and compares every coefficient with a behavioral model
// depends on rzd_pkg and rle_zigzag_dequantizer_top
module tb_rle_zigzag_dequantizer_top;

    localparam int DIR_N        = 23;
    localparam int PHASE_N      = 6;
    localparam int PHASE_ITEMS  = 56;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 10;

    typedef enum logic [1:0] {RDY_FULL, RDY_MOSTLY, RDY_SPARSE} rdy_mode_t;

    typedef struct packed {
        logic signed [rzd_pkg::COEF_W-1:0] coef;
        logic [rzd_pkg::IDX_W-1:0]         row;
        logic [rzd_pkg::IDX_W-1:0]         col;
        logic                              last;
        logic                              ovf;
    } coef_t;

    typedef struct packed {
        bit                               wr;
        logic [rzd_pkg::SCALE_W-1:0]      scale;
        logic [rzd_pkg::RUN_W-1:0]        run;
        logic signed [rzd_pkg::VAL_W-1:0] val;
        bit                               chk;
        coef_t                            want;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{0,   0,  0,     1, 1, '{4096,       0, 0, 0, 0}},
        '{0,   0,  0,  2047, 1, '{5764352,    0, 1, 0, 0}},
        '{0,   0,  0, -2048, 1, '{-6291456,   1, 0, 0, 0}},
        '{0,   0,  0,     0, 1, '{0,          7, 7, 1, 0}},
        '{0,   0,  0,     0, 1, '{0,          7, 7, 1, 0}},
        '{0,   0, 63,     5, 1, '{126720,     7, 7, 1, 0}},
        '{0,   0,  7,    -3, 0, '0},
        '{0,   0, 10,     0, 0, '0},
        '{0,   0, 60,     1, 1, '{0,          7, 7, 1, 1}},
        '{0,   0,  0,     0, 0, '0},
        '{0,   0, 63,    -1, 1, '{-25344,     7, 7, 1, 0}},
        '{0,   0,  0,     0, 0, '0},
        '{0,   0,  1,     0, 0, '0},
        '{0,   0, 62,     7, 1, '{0,          7, 7, 1, 1}},
        '{0,   0,  5,     7, 0, '0},
        '{1, 511, 56,  2047, 1, '{126568057,  6, 5, 0, 0}},
        '{0,   0,  0,     0, 1, '{0,          7, 7, 1, 0}},
        '{0,   0, 56, -2048, 1, '{-126629888, 6, 5, 0, 0}},
        '{0,   0,  0,     0, 1, '{0,          7, 7, 1, 0}},
        '{1,   0,  0, -2048, 1, '{0,          0, 0, 0, 0}},
        '{0,   0,  0,     0, 0, '0},
        '{1,   1,  0,    -1, 1, '{-16,        0, 0, 0, 0}},
        '{0,   0,  0,     0, 0, '0}
    };

    localparam logic [rzd_pkg::SCALE_W-1:0] PHASE_SCALES [4] = '{511, 0, 1, 256};

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [rzd_pkg::SCALE_W-1:0]     cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [rzd_pkg::S_TDATA_W-1:0]   s_tdata     = '0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [rzd_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;

    // model state
    logic [rzd_pkg::SCALE_W-1:0]     qscale       = rzd_pkg::SCALE_RESET;
    int                              blk_pos      = 0;
    bit                              term_pending = 1'b0;
    coef_t                           pending_coefs [$];

    bit                              cur_chk = 1'b0;
    coef_t                           cur_want = '0;
    int                              fail_cnt = 0;
    int                              burst_left = 0;
    rdy_mode_t                       rdy_mode = RDY_FULL;
    int                              rdy_left = 0;

    rle_zigzag_dequantizer_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic push_coef(input int pos, input logic signed [rzd_pkg::COEF_W-1:0] c,
                             input logic ovf);
        coef_t      e;
        logic [5:0] zz_idx;
        zz_idx = rzd_pkg::ZZ_ORDER[pos];
        e.coef = c;
        e.row  = zz_idx[5:3];
        e.col  = zz_idx[2:0];
        e.last = (pos == 63);
        e.ovf  = ovf;
        pending_coefs.push_back(e);
    endtask

    task automatic dequantize_pair(input logic [rzd_pkg::RUN_W-1:0] run,
                                   input logic signed [rzd_pkg::VAL_W-1:0] val);
        int pos;
        int prod;
        pos = blk_pos;
        if (term_pending) begin
            term_pending = 1'b0;
            blk_pos      = 0;
        end else if (run == 0 && val == 0) begin
            for (int p = pos; p <= 63; p++) push_coef(p, '0, 1'b0);
            blk_pos = 0;
        end else if (pos + int'(run) > 63) begin
            for (int p = pos; p <= 63; p++) push_coef(p, '0, 1'b1);
            blk_pos      = 0;
            term_pending = 1'b1;
        end else begin
            for (int i = 0; i < int'(run); i++) begin
                push_coef(pos, '0, 1'b0);
                pos++;
            end
            prod = int'(val) * int'(rzd_pkg::QTABLE[rzd_pkg::ZZ_ORDER[pos]]) * int'(qscale);
            push_coef(pos, prod[rzd_pkg::COEF_W-1:0], 1'b0);
            if (pos == 63) begin
                blk_pos      = 0;
                term_pending = 1'b1;
            end else begin
                blk_pos = pos + 1;
            end
        end
    endtask

    // model update and result check
    always @(posedge aclk) begin
        coef_t got;
        coef_t want;
        if (aresetn) begin
            if (cfg_wr_en) qscale = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                dequantize_pair(s_tdata[5:0], s_tdata[17:6]);
                if (cur_chk && pending_coefs.size() != 0)
                    pending_coefs[pending_coefs.size()-1] = cur_want;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[27:0], m_tdata[30:28], m_tdata[33:31], m_tlast, m_tuser};
                if (pending_coefs.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("unexpected item: coef %0d row %0d col %0d last %b ovf %b",
                                 got.coef, got.row, got.col, got.last, got.ovf);
                end else begin
                    want = pending_coefs.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"mismatch: exp coef %0d row %0d col %0d last %b ovf %b,",
                                      " got coef %0d row %0d col %0d last %b ovf %b"},
                                     want.coef, want.row, want.col, want.last, want.ovf,
                                     got.coef, got.row, got.col, got.last, got.ovf);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = rdy_mode_t'($urandom_range(0, 2));
            rdy_left = $urandom_range(8, 80);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_FULL:   m_tready <= 1'b1;
            RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
            default:    m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_pair(input logic [rzd_pkg::RUN_W-1:0] run,
                             input logic signed [rzd_pkg::VAL_W-1:0] val,
                             input bit chk, input coef_t want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  = {6'b0, val, run};
        cur_chk  = chk;
        cur_want = want;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (pending_coefs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_scale(input logic [rzd_pkg::SCALE_W-1:0] v);
        cfg_wr_data = v;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    initial begin
        logic [rzd_pkg::RUN_W-1:0]        run;
        logic signed [rzd_pkg::VAL_W-1:0] val;
        int                               r;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].wr) begin
                drain();
                write_scale(DIR_ROWS[i].scale);
            end
            send_pair(DIR_ROWS[i].run, DIR_ROWS[i].val, DIR_ROWS[i].chk, DIR_ROWS[i].want);
        end

        for (int ph = 0; ph < PHASE_N; ph++) begin
            drain();
            write_scale((ph < 4) ? PHASE_SCALES[ph]
                                 : rzd_pkg::SCALE_W'($urandom_range(0, 511)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (term_pending) begin
                    // terminator of a filled block
                    if (r < 70) begin
                        run = '0;
                        val = '0;
                    end else begin
                        run = rzd_pkg::RUN_W'($urandom);
                        val = rzd_pkg::VAL_W'($urandom);
                    end
                end else if (r < 8) begin
                    run = '0;
                    val = '0;
                end else if (r < 14) begin
                    run = rzd_pkg::RUN_W'($urandom);
                    val = rzd_pkg::VAL_W'($urandom);
                end else if (r < 18) begin
                    run = rzd_pkg::RUN_W'(63 - blk_pos);
                    val = rzd_pkg::VAL_W'($urandom);
                end else if (r < 22) begin
                    run = rzd_pkg::RUN_W'($urandom);
                    val = '0;
                end else begin
                    run = rzd_pkg::RUN_W'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) != 0) begin
                        val = rzd_pkg::VAL_W'($urandom);
                    end else begin
                        val = rzd_pkg::VAL_W'($urandom_range(1, 31));
                        if ($urandom_range(0, 1) != 0) val = -val;
                    end
                    if (val == 0) val = 1;
                end
                send_pair(run, val, 1'b0, '0);
            end
        end

        drain();
        if (fail_cnt == 0 && pending_coefs.size() == 0) begin
            $display("tb_rle_zigzag_dequantizer_top passed");
        end else begin
            $display("tb_rle_zigzag_dequantizer_top failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb_rle_zigzag_dequantizer_top failed");
        $finish;
    end

endmodule
